// ----- hw/rtl/ufss_pkg.sv -----
// package: command codes, status codes and request/result types of the slot scheduler
`timescale 1ns / 1ps
`default_nettype none
package ufss_pkg;

	localparam logic [1:0] CMD_CLEAR    = 2'd0;
	localparam logic [1:0] CMD_ADD      = 2'd1;
	localparam logic [1:0] CMD_SCHEDULE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISSED   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BAD_RANK = 2'd3;

	localparam logic [31:0] CAP_UNBOUNDED = 32'hFFFF_FFFF;
	localparam logic [15:0] NO_RELEASE    = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [14:0] release_req;
		logic [7:0]  rank_index;
		logic [7:0]  required;
		logic [14:0] deadline;
	} req_t;

	typedef struct packed {
		logic [7:0]  assigned_rank;
		logic [15:0] schedule_date;
		logic [1:0]  status;
	} res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ufss_div.sv -----
// restoring divider: 33-bit dividend by 8-bit divisor, one quotient bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module ufss_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [32:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic             done,
	output logic [32:0]      quotient
);
	logic [32:0] quo_q;
	logic [8:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [9:0]  trial;

	assign trial = {rem_q, quo_q[32]} - {2'b00, dvs_q};

	// shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= run_q && !go && (cnt_q == 6'd1);
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[9]) begin
				rem_q <= trial[8:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ----- hw/rtl/union_find_slot_scheduler.sv -----
// top level: rank table in memories, union-find walk and date computation
// clear, add, zero-requirement and bad-index requests go straight to the output state; the result
// strobe follows it, and the next request is accepted once the sequencer is back in idle.
// a schedule request walks the parent chain on each find and merges each full rank; it ends with
// the divider, except for an exact fill (which skips the division).
// busy is high while a request runs; the receiver cannot stall; after reset the table is empty
// and available is 1, no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module union_find_slot_scheduler #(
	parameter int MAX_RANKS = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire ufss_pkg::req_t  request,
	output logic                 done,
	output ufss_pkg::res_t       result,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata
);
	localparam int AW = $clog2(MAX_RANKS);
	localparam int CW = AW + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FRD    = 4'd1;  // read parent of root_q
	localparam logic [3:0] S_FCHK   = 4'd2;
	localparam logic [3:0] S_CRD    = 4'd3;  // compression: read parent of cur_q
	localparam logic [3:0] S_CCHK   = 4'd4;
	localparam logic [3:0] S_RRD    = 4'd5;  // read rank fields
	localparam logic [3:0] S_RCHK   = 4'd6;
	localparam logic [3:0] S_DIV    = 4'd7;
	localparam logic [3:0] S_DWAIT  = 4'd8;
	localparam logic [3:0] S_NXTRD  = 4'd9;  // read date of next rank
	localparam logic [3:0] S_NXTCHK = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	// rank table memories
	logic [14:0] date_mem [MAX_RANKS];
	logic [31:0] cap_mem  [MAX_RANKS];
	logic [31:0] cons_mem [MAX_RANKS];
	logic [AW-1:0] par_mem [MAX_RANKS];

	logic [7:0]    avail_q;
	logic [CW-1:0] count_q;
	logic [15:0]   last_q;
	logic [3:0]    st_q;
	ufss_pkg::req_t req_q;
	logic [AW-1:0] start_q, root_q, cur_q, r_q;
	logic          merge_q;   // find is for the successor of r_q
	logic          exact_q;   // r_q filled exactly, stop after the link
	logic          new_cap_q; // newest rank still needs its unbounded capacity
	logic [8:0]    rem_q;     // fits: at most 255 + nothing carried beyond
	logic [14:0]   date_rd;
	logic [31:0]   cap_rd, cons_rd;
	logic [AW-1:0] par_rd;
	logic [32:0]   cum_q;
	logic [14:0]   rdate_q;
	logic [15:0]   sdate_q;
	logic [1:0]    status_q;
	logic [7:0]    arank_q;

	// memory address and write controls
	logic [AW-1:0] raddr;
	logic          pw_en, cw_en, cpw_en, dw_en;
	logic [AW-1:0] pw_addr, cw_addr, cpw_addr, dw_addr;
	logic [AW-1:0] pw_data;
	logic [31:0]   cw_data, cpw_data;
	logic [14:0]   dw_data;

	logic        div_go, div_done;
	logic [32:0] div_q;
	logic [7:0]  avail_eff;
	logic [32:0] cum_now;
	logic        is_last;
	logic [16:0] sum_date;
	logic        add_grow, add_new, bad_rank, fits, exact;

	assign avail_eff = (avail_q == 8'd0) ? 8'd1 : avail_q;
	assign cum_now   = {1'b0, cons_rd} + {24'd0, rem_q};
	assign is_last   = ({1'b0, r_q} + CW'(1)) >= count_q;
	assign sum_date  = {2'b00, rdate_q} + div_q[16:0];

	// request decode
	assign add_grow = (count_q == '0) || ({1'b0, request.release_req} > last_q);
	assign add_new  = (request.command == ufss_pkg::CMD_ADD) && add_grow
		&& (count_q < CW'(MAX_RANKS));
	assign bad_rank = (CW+8)'(request.rank_index) >= (CW+8)'(count_q);

	// rank fill outcome
	assign fits  = is_last || (cons_rd < cap_rd && cum_now < {1'b0, cap_rd});
	assign exact = !is_last && cons_rd < cap_rd && cum_now == {1'b0, cap_rd};

	ufss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (cum_q - 33'd1),
		.divisor  (avail_eff),
		.done     (div_done),
		.quotient (div_q)
	);

	// synchronous memory read and write ports
	always_ff @(posedge clk) begin
		date_rd <= date_mem[raddr];
		cap_rd  <= cap_mem[raddr];
		cons_rd <= cons_mem[raddr];
		par_rd  <= par_mem[raddr];
		if (pw_en) par_mem[pw_addr] <= pw_data;
		if (cw_en) cons_mem[cw_addr] <= cw_data;
		if (cpw_en) cap_mem[cpw_addr] <= cpw_data;
		if (dw_en) date_mem[dw_addr] <= dw_data;
	end

	// read address per state
	always_comb begin
		unique case (st_q)
			S_FRD:   raddr = root_q;
			S_CRD:   raddr = cur_q;
			S_NXTRD: raddr = r_q + AW'(1);
			default: raddr = r_q;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			avail_q   <= 8'd1;
			count_q   <= '0;
			last_q    <= ufss_pkg::NO_RELEASE;
			done      <= 1'b0;
			new_cap_q <= 1'b0;
		end else begin
			done      <= (st_q == S_OUT);
			new_cap_q <= (st_q == S_IDLE) && start && add_new && (count_q != '0);
			if (cfg_we) avail_q <= cfg_wdata;
			unique case (st_q)
				S_IDLE: if (start) begin
					req_q <= request;
					if (request.command == ufss_pkg::CMD_CLEAR) begin
						count_q  <= '0;
						last_q   <= ufss_pkg::NO_RELEASE;
						arank_q  <= '0;
						sdate_q  <= '0;
						status_q <= ufss_pkg::ST_OK;
						st_q     <= S_OUT;
					end else if (request.command == ufss_pkg::CMD_ADD) begin
						sdate_q <= '0;
						st_q    <= S_OUT;
						if (add_new) begin
							count_q  <= count_q + CW'(1);
							last_q   <= {1'b0, request.release_req};
							arank_q  <= 8'(count_q);
							status_q <= ufss_pkg::ST_OK;
						end else if (add_grow) begin
							arank_q  <= '0;
							status_q <= ufss_pkg::ST_FULL;
						end else begin
							arank_q  <= 8'(count_q - CW'(1));
							status_q <= ufss_pkg::ST_OK;
						end
					end else if (request.command == ufss_pkg::CMD_SCHEDULE) begin
						arank_q <= '0;
						if (request.required == 8'd0) begin
							sdate_q  <= {1'b0, request.release_req};
							status_q <= ufss_pkg::ST_OK;
							st_q     <= S_OUT;
						end else if (bad_rank) begin
							sdate_q  <= '0;
							status_q <= ufss_pkg::ST_BAD_RANK;
							st_q     <= S_OUT;
						end else begin
							sdate_q  <= '0;
							status_q <= ufss_pkg::ST_OK;
							start_q  <= AW'(request.rank_index);
							root_q   <= AW'(request.rank_index);
							rem_q    <= {1'b0, request.required};
							merge_q  <= 1'b0;
							exact_q  <= 1'b0;
							st_q     <= S_FRD;
						end
					end else begin
						arank_q  <= '0;
						sdate_q  <= '0;
						status_q <= ufss_pkg::ST_OK;
						st_q     <= S_OUT;
					end
				end
				S_FRD: st_q <= S_FCHK;
				S_FCHK: begin
					if (par_rd != root_q) begin
						root_q <= par_rd;
						st_q   <= S_FRD;
					end else begin
						cur_q <= start_q;
						st_q  <= S_CRD;
					end
				end
				S_CRD: st_q <= S_CCHK;
				S_CCHK: begin
					if (cur_q != root_q) begin
						cur_q <= par_rd;
						st_q  <= S_CRD;
					end else begin
						// a successor find also links the full rank here
						r_q     <= root_q;
						merge_q <= 1'b0;
						st_q    <= (merge_q && exact_q) ? S_OUT : S_RRD;
					end
				end
				S_RRD: st_q <= S_RCHK;
				S_RCHK: begin
					rdate_q <= date_rd;
					cum_q   <= cum_now;
					if (fits) begin
						st_q <= S_DIV;
					end else begin
						if (cons_rd < cap_rd) rem_q <= 9'(cum_now - {1'b0, cap_rd});
						exact_q <= exact;
						// find root of successor, then jump there
						start_q <= r_q + AW'(1);
						root_q  <= r_q + AW'(1);
						merge_q <= 1'b1;
						st_q    <= exact ? S_NXTRD : S_FRD;
					end
				end
				S_NXTRD: st_q <= S_NXTCHK;
				S_NXTCHK: begin
					// exact fill: issue just before the successor's date
					sdate_q <= {1'b0, date_rd} - 16'd1;
					st_q    <= S_FRD;
				end
				S_DIV: st_q <= S_DWAIT;
				S_DWAIT: if (div_done) begin
					sdate_q <= (div_q[32:16] != 17'd0 || sum_date[16]) ? 16'hFFFF
						: sum_date[15:0];
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (req_q.command == ufss_pkg::CMD_SCHEDULE && status_q == ufss_pkg::ST_OK
							&& req_q.required != 8'd0 && sdate_q >= {1'b0, req_q.deadline})
						status_q <= ufss_pkg::ST_MISSED;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// write controls
	always_comb begin
		pw_en = 1'b0; pw_addr = cur_q; pw_data = root_q;
		cw_en = 1'b0; cw_addr = r_q; cw_data = '0;
		cpw_en = 1'b0; cpw_addr = '0; cpw_data = '0;
		dw_en = 1'b0; dw_addr = '0; dw_data = request.release_req;
		if (st_q == S_IDLE && start && add_new) begin
			dw_en = 1'b1; dw_addr = AW'(count_q);
			cw_en = 1'b1; cw_addr = AW'(count_q); cw_data = '0;
			pw_en = 1'b1; pw_addr = AW'(count_q); pw_data = AW'(count_q);
			cpw_en = 1'b1;
			if (count_q == '0) begin
				cpw_addr = '0; cpw_data = ufss_pkg::CAP_UNBOUNDED;
			end else begin
				cpw_addr = AW'(count_q - CW'(1));
				cpw_data = 32'(17'({1'b0, request.release_req} - last_q) * avail_eff);
			end
		end
		// a new rank gets its unbounded capacity in the cycle after the previous rank's is written
		if (new_cap_q) begin
			cpw_en = 1'b1; cpw_addr = AW'(count_q - CW'(1));
			cpw_data = ufss_pkg::CAP_UNBOUNDED;
		end
		if (st_q == S_CCHK && cur_q != root_q) begin
			pw_en = 1'b1;
		end
		if (st_q == S_CCHK && cur_q == root_q && merge_q) begin
			pw_en = 1'b1; pw_addr = r_q; pw_data = root_q;
		end
		if (st_q == S_RCHK) begin
			cw_en = 1'b1;
			if (is_last)
				cw_data = cum_now[32] ? 32'hFFFF_FFFF : cum_now[31:0];
			else if (fits)
				cw_data = cum_now[31:0];
			else
				cw_data = cap_rd;
		end
	end

	assign div_go = (st_q == S_DIV);
	assign busy   = (st_q != S_IDLE);
	assign result.assigned_rank = arank_q;
	assign result.schedule_date = sdate_q;
	assign result.status = (req_q.command == ufss_pkg::CMD_SCHEDULE
		&& status_q == ufss_pkg::ST_OK && req_q.required != 8'd0
		&& sdate_q >= {1'b0, req_q.deadline}) ? ufss_pkg::ST_MISSED : status_q;
endmodule
`default_nettype wire
